// ----- sv/mspm_pkg.sv -----
// Shared constants, command and status codes, and the per-slot record type.
`default_nettype none

package mspm_pkg;

  localparam int NUM_SLOTS_DEF = 16;
  localparam int MAX_SLOTS     = 16;
  localparam int SAMPLE_BITS   = 24;
  localparam int SLOT_BITS     = 4;
  localparam int CMD_BITS      = 3;
  localparam int COEFF_BITS    = 16;
  localparam int GAIN_BITS     = 16;
  localparam int GAIN_FRAC     = 12;
  localparam int PROD_BITS     = 17;
  localparam int LANES         = 4;

  localparam logic [PROD_BITS-1:0] UNITY_PRODUCT = PROD_BITS'(1) << COEFF_BITS;

  typedef logic [SAMPLE_BITS-1:0] sample_t;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_ALLOC     = 3'd0,
    CMD_FREE      = 3'd1,
    CMD_SET_DECAY = 3'd2,
    CMD_FRAME     = 3'd3,
    CMD_RESET     = 3'd4,
    CMD_READ      = 3'd5
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INACTIVE = 2'd1,
    ST_NO_FREE  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL,
    S_MAG,
    S_WB
  } fsm_t;

  typedef struct packed {
    logic [COEFF_BITS-1:0]   decay;
    logic [PROD_BITS-1:0]    prod;
    sample_t [LANES-1:0]     peaks;
    sample_t [LANES-1:0]     meters;
  } slot_rec_t;

endpackage

`default_nettype wire

// ----- sv/multi_slot_stereo_peak_meter.sv -----
// Multi-slot stereo peak meter: top level with slot record memory and sequencer.
// Usage:
//   Input channel (in_valid/in_ready) carries one command transaction: alloc,
//   free, set decay, frame, reset meters or read meters, addressed by in_slot.
//   Result channel (out_valid/out_ready) returns exactly one transaction per
//   command: status, granted slot, gained samples and the slot's four meters.
//   Each command passes through accept plus memory read, gain and decay
//   product multiply, meter multiply, then compare and write back. The
//   result is registered in write-back, and the next command is taken only
//   after the sequencer returns to idle. The slot record memory (one
//   read-modify-write per command) and the two dependent multiplies call for this.
//   When the receiver stalls, the result waits in the output register; one
//   more command is accepted and processed and then holds in write-back until
//   the output register frees, so no transaction is lost or repeated.
//   Reset marks every slot free. Slot records are not cleared: alloc writes
//   the whole record, and an inactive slot always reports zero meters.
`default_nettype none

module multi_slot_stereo_peak_meter
  import mspm_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [CMD_BITS-1:0]           in_cmd,
  input  logic [SLOT_BITS-1:0]          in_slot,
  input  logic [COEFF_BITS-1:0]         in_decay_coeff,
  input  logic [GAIN_BITS-1:0]          in_gain,
  input  logic signed [SAMPLE_BITS-1:0] in_raw_left,
  input  logic signed [SAMPLE_BITS-1:0] in_raw_right,
  input  logic signed [SAMPLE_BITS-1:0] in_limited_left,
  input  logic signed [SAMPLE_BITS-1:0] in_limited_right,
  input  logic                          in_block_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [SLOT_BITS-1:0]          out_slot_granted,
  output logic signed [SAMPLE_BITS-1:0] out_gained_left,
  output logic signed [SAMPLE_BITS-1:0] out_gained_right,
  output logic [SAMPLE_BITS-1:0]        out_pre_meter_left,
  output logic [SAMPLE_BITS-1:0]        out_pre_meter_right,
  output logic [SAMPLE_BITS-1:0]        out_post_meter_left,
  output logic [SAMPLE_BITS-1:0]        out_post_meter_right
);

  localparam int SLOTS   = (NUM_SLOTS < MAX_SLOTS) ? NUM_SLOTS : MAX_SLOTS;
  localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int GPROD_W = SAMPLE_BITS + GAIN_BITS;
  localparam int P_W     = GPROD_W + 1 - GAIN_FRAC;
  localparam int PMUL_W  = PROD_BITS + COEFF_BITS;
  localparam int MMUL_W  = SAMPLE_BITS + PROD_BITS;
  localparam logic [GPROD_W:0] ROUND_C = (GPROD_W + 1)'(1) << (GAIN_FRAC - 1);
  localparam sample_t POS_LIM = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam sample_t NEG_LIM = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  function automatic sample_t mag_of(input sample_t x);
    return x[SAMPLE_BITS-1] ? (~x + 1'b1) : x;
  endfunction

  fsm_t state_r, state_nxt;
  logic accept, mul_load, mag_load, out_load;

  logic [SLOTS-1:0] active_r, active_nxt;

  logic             free_found;
  logic [IDX_W-1:0] free_idx;
  logic             in_range;
  logic             in_active;

  logic [CMD_BITS-1:0]   cmd_r;
  logic [SLOT_BITS-1:0]  slot_r;
  logic [COEFF_BITS-1:0] decay_r;
  logic [GAIN_BITS-1:0]  gain_r;
  sample_t [1:0]         raw_r;
  sample_t [1:0]         rabs_r;
  logic [1:0]            neg_r;
  sample_t [1:0]         lmag_r;
  logic                  end_r;
  logic                  in_range_r;
  logic                  valid_r;
  logic                  found_r;
  logic [IDX_W-1:0]      grant_r;
  logic [IDX_W-1:0]      addr_r;

  logic [1:0][GPROD_W-1:0]      gprod_r, gprod_nxt;
  logic [PROD_BITS-1:0]         prod_new_r, prod_new_nxt;
  sample_t [1:0]                gmag_r, gmag_nxt;
  logic [LANES-1:0][MMUL_W-1:0] mprod_r, mprod_nxt;

  slot_rec_t ram_rdata, rec_new;
  logic      ram_we;
  logic      wr_item, act_set, act_clr;

  logic                  out_valid_r, out_valid_nxt;
  status_t               status_r, status_nxt;
  logic [SLOT_BITS-1:0]  grant_out_r, grant_out_nxt;
  sample_t [1:0]         gained_r, gained_nxt;
  sample_t [LANES-1:0]   meters_out_r, meters_out_nxt;

  // Slot lookup and first-free search
  assign in_range  = int'(in_slot) < NUM_SLOTS;
  assign in_active = in_range && active_r[in_slot[IDX_W-1:0]];

  always_comb begin
    free_found = 1'b0;
    free_idx   = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (!active_r[i]) begin
        free_found = 1'b1;
        free_idx   = IDX_W'(i);
      end
    end
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_MUL;
      S_MUL:  state_nxt = S_MAG;
      S_MAG:  state_nxt = S_WB;
      S_WB:   if (!out_valid_r || out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    mul_load = 1'b0;
    mag_load = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      S_IDLE: in_ready = 1'b1;
      S_MUL:  mul_load = 1'b1;
      S_MAG:  mag_load = 1'b1;
      S_WB:   out_load = !out_valid_r || out_ready;
      default: in_ready = 1'b0;
    endcase
  end

  assign accept = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      active_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      active_r    <= active_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Capture the transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= in_cmd;
      slot_r     <= in_slot;
      decay_r    <= in_decay_coeff;
      gain_r     <= in_gain;
      raw_r      <= {in_raw_right, in_raw_left};
      rabs_r     <= {mag_of(in_raw_right), mag_of(in_raw_left)};
      neg_r      <= {in_raw_right[SAMPLE_BITS-1], in_raw_left[SAMPLE_BITS-1]};
      lmag_r     <= {mag_of(in_limited_right), mag_of(in_limited_left)};
      end_r      <= in_block_end;
      in_range_r <= in_range;
      valid_r    <= in_active;
      found_r    <= free_found;
      grant_r    <= free_idx;
      addr_r     <= (in_cmd == CMD_ALLOC) ? free_idx : in_slot[IDX_W-1:0];
    end
  end

  mspm_ram #(
    .WIDTH ($bits(slot_rec_t)),
    .DEPTH (SLOTS),
    .AW    (IDX_W)
  ) u_rec_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (rec_new),
    .re    (accept),
    .raddr (in_slot[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Gain and decay product multiply
  always_comb begin
    for (int k = 0; k < 2; k++) begin
      gprod_nxt[k] = GPROD_W'(rabs_r[k]) * GPROD_W'(gain_r);
    end
    prod_new_nxt = PROD_BITS'((PMUL_W'(ram_rdata.prod) * PMUL_W'(ram_rdata.decay))
                              >> COEFF_BITS);
  end

  // Round, saturate, meter multiply
  always_comb begin
    logic [GPROD_W:0] psum;
    logic [P_W-1:0]   p;
    for (int k = 0; k < 2; k++) begin
      psum = {1'b0, gprod_r[k]} + ROUND_C;
      p    = psum[GPROD_W:GAIN_FRAC];
      if (neg_r[k]) begin
        gmag_nxt[k] = (p > P_W'(NEG_LIM)) ? NEG_LIM : p[SAMPLE_BITS-1:0];
      end else begin
        gmag_nxt[k] = (p > P_W'(POS_LIM)) ? POS_LIM : p[SAMPLE_BITS-1:0];
      end
    end
    for (int k = 0; k < LANES; k++) begin
      mprod_nxt[k] = MMUL_W'(ram_rdata.meters[k]) * MMUL_W'(prod_new_r);
    end
  end

  always_ff @(posedge clk) begin
    if (mul_load) begin
      gprod_r    <= gprod_nxt;
      prod_new_r <= prod_new_nxt;
    end
    if (mag_load) begin
      gmag_r  <= gmag_nxt;
      mprod_r <= mprod_nxt;
    end
  end

  // Write back and result
  always_comb begin
    sample_t [LANES-1:0] pk;
    sample_t [LANES-1:0] peak_upd;
    sample_t [LANES-1:0] fresh;
    sample_t             cur;
    pk = {lmag_r[1], lmag_r[0], gmag_r[1], gmag_r[0]};
    for (int k = 0; k < LANES; k++) begin
      peak_upd[k] = (pk[k] > ram_rdata.peaks[k]) ? pk[k] : ram_rdata.peaks[k];
      cur         = mprod_r[k][COEFF_BITS +: SAMPLE_BITS];
      fresh[k]    = (peak_upd[k] > cur) ? peak_upd[k] : cur;
    end
    rec_new        = ram_rdata;
    wr_item        = 1'b0;
    act_set        = 1'b0;
    act_clr        = 1'b0;
    status_nxt     = ST_OK;
    grant_out_nxt  = slot_r;
    gained_nxt     = '0;
    meters_out_nxt = '0;
    unique case (cmd_r)
      CMD_ALLOC: begin
        if (found_r) begin
          rec_new.decay  = decay_r;
          rec_new.prod   = UNITY_PRODUCT;
          rec_new.peaks  = '0;
          rec_new.meters = '0;
          wr_item        = 1'b1;
          act_set        = 1'b1;
          grant_out_nxt  = SLOT_BITS'(grant_r);
        end else begin
          status_nxt = ST_NO_FREE;
        end
      end
      CMD_FREE: begin
        if (in_range_r) begin
          rec_new.prod   = UNITY_PRODUCT;
          rec_new.peaks  = '0;
          rec_new.meters = '0;
          wr_item        = 1'b1;
          act_clr        = 1'b1;
        end else begin
          status_nxt = ST_INACTIVE;
        end
      end
      CMD_SET_DECAY: begin
        if (valid_r) begin
          rec_new.decay  = decay_r;
          wr_item        = 1'b1;
          meters_out_nxt = ram_rdata.meters;
        end else begin
          status_nxt = ST_INACTIVE;
        end
      end
      CMD_FRAME: begin
        if (valid_r) begin
          for (int k = 0; k < 2; k++) begin
            gained_nxt[k] = neg_r[k] ? (~gmag_r[k] + 1'b1) : gmag_r[k];
          end
          wr_item = 1'b1;
          if (end_r) begin
            rec_new.meters = fresh;
            rec_new.peaks  = '0;
            rec_new.prod   = UNITY_PRODUCT;
          end else begin
            rec_new.peaks = peak_upd;
            rec_new.prod  = prod_new_r;
          end
          meters_out_nxt = rec_new.meters;
        end else begin
          status_nxt = ST_INACTIVE;
          gained_nxt = raw_r;
        end
      end
      CMD_RESET: begin
        if (valid_r) begin
          rec_new.meters = '0;
          wr_item        = 1'b1;
        end else begin
          status_nxt = ST_INACTIVE;
        end
      end
      default: begin
        if (valid_r) begin
          meters_out_nxt = ram_rdata.meters;
        end else begin
          status_nxt = ST_INACTIVE;
        end
      end
    endcase
  end

  assign ram_we = out_load && wr_item;

  always_comb begin
    active_nxt = active_r;
    if (out_load && act_set) begin
      active_nxt[addr_r] = 1'b1;
    end
    if (out_load && act_clr) begin
      active_nxt[addr_r] = 1'b0;
    end
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (out_load) begin
      status_r     <= status_nxt;
      grant_out_r  <= grant_out_nxt;
      gained_r     <= gained_nxt;
      meters_out_r <= meters_out_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_status           = status_r;
  assign out_slot_granted     = grant_out_r;
  assign out_gained_left      = gained_r[0];
  assign out_gained_right     = gained_r[1];
  assign out_pre_meter_left   = meters_out_r[0];
  assign out_pre_meter_right  = meters_out_r[1];
  assign out_post_meter_left  = meters_out_r[2];
  assign out_post_meter_right = meters_out_r[3];

`ifndef SYNTHESIS
  a_write_in_wb: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> state_r == S_WB)
    else $error("record write outside write-back");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_MUL)
    else $error("accepted transaction did not start");

  a_result_from_wb: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_WB))
    else $error("result raised outside write-back");

  a_grant_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WB && cmd_r == CMD_ALLOC && found_r) |-> !active_r[grant_r])
    else $error("alloc granted an active slot");
`endif

endmodule

`default_nettype wire

// ----- sv/mspm_ram.sv -----
// Generic simple dual-port RAM with registered read.
`default_nettype none

module mspm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire
